FILE: design/knn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package knn_pkg;
   localparam int MaxPoints     = 256;
   localparam int MaxDims       = 8;
   localparam int MaxNeighbours = 16;
   localparam int CoordBits     = 16;
   localparam int PtW   = 8;
   localparam int DimW  = 3;
   localparam int AddrW = PtW + DimW;
   localparam int DiffW = CoordBits + 1;
   localparam int SqW   = 2 * DiffW;
   localparam int DistW = 35;
   localparam int SlotW = 4;
   localparam int CntW  = 5;

   localparam logic [1:0] CSR_NEIGHBOR_COUNT = 2'd0;
   localparam logic [1:0] CSR_POINTS_IN_USE  = 2'd1;
   localparam logic [1:0] CSR_DIMS_IN_USE    = 2'd2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // controller -> datapath commands
   typedef struct packed {
      logic             load_wr;     // write one coordinate
      logic             clear_list;  // start of query
      logic             rd_en;       // issue store read pair
      logic [PtW-1:0]   cand;        // candidate point
      logic [DimW-1:0]  dim;         // dimension being read
      logic             acc_valid;   // read issued this cycle, data to accumulate
      logic             acc_first;   // first dimension of a candidate
      logic             ins_check;   // sum complete, run insert
      logic             shift_step;  // one insertion shift step
      logic [SlotW-1:0] out_slot;    // list slot to present
   } knn_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic             any_present; // accumulated candidate has a shared dim
      logic             ins_take;    // candidate enters the list
      logic             shift_more;  // insertion must move further
      logic [CntW-1:0]  count;       // list fill
      logic [PtW-1:0]   slot_index;  // index at out_slot
   } knn_stat_type;
endpackage
`default_nettype wire

FILE: design/knn_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module knn_datapath
   import knn_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire knn_cmd_type          cmd,
   input  wire logic [PtW-1:0]       target,
   input  wire logic [DimW-1:0]      load_dim,
   input  wire logic [PtW-1:0]       load_point,
   input  wire logic [CoordBits-1:0] load_value,
   input  wire logic                 load_missing,
   input  wire logic [CntW-1:0]      limit,
   output knn_stat_type              stat
);
   // coordinate store: value plus missing flag, two read ports
   logic [CoordBits:0] store_mem [0:MaxPoints*MaxDims-1];
   logic [CoordBits:0] rd_a_ff, rd_b_ff;
   logic [AddrW-1:0]   wr_addr, a_addr, b_addr;

   assign wr_addr = {load_point, load_dim};
   assign a_addr  = {target, cmd.dim};
   assign b_addr  = {cmd.cand, cmd.dim};

   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         store_mem[wr_addr] <= {load_missing, load_value};
      end
      if (cmd.rd_en) begin
         rd_a_ff <= store_mem[a_addr];
         rd_b_ff <= store_mem[b_addr];
      end
   end

   // difference and square, registered between
   logic [DiffW-1:0] mag_ff, mag_in;
   logic             pres_ff, pres_in;
   logic [SqW-1:0]   sq_ff;
   logic signed [DiffW-1:0] diff;
   logic             rv_ff, rf_ff, mv_ff, mf_ff, sqv_ff, sqf_ff, sqp_ff;

   always_comb begin
      diff = DiffW'($signed(rd_a_ff[CoordBits-1:0])) - DiffW'($signed(rd_b_ff[CoordBits-1:0]));
      mag_in = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
      pres_in = !rd_a_ff[CoordBits] && !rd_b_ff[CoordBits];
   end

   // valid and first-dimension flags travel with the data:
   // read register, magnitude register, square register
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff  <= 1'b0;
         mv_ff  <= 1'b0;
         sqv_ff <= 1'b0;
      end else begin
         rv_ff  <= cmd.acc_valid;
         mv_ff  <= rv_ff;
         sqv_ff <= mv_ff;
      end
      rf_ff   <= cmd.acc_first;
      mf_ff   <= rf_ff;
      sqf_ff  <= mf_ff;
      mag_ff  <= mag_in;
      pres_ff <= pres_in;
      sq_ff   <= pres_ff ? SqW'(mag_ff) * SqW'(mag_ff) : '0;
      sqp_ff  <= pres_ff;
   end

   // accumulator
   logic [DistW-1:0] sum_ff;
   logic             any_ff;
   always_ff @(posedge clock) begin
      if (sqv_ff) begin
         sum_ff <= (sqf_ff ? '0 : sum_ff) + DistW'(sq_ff);
         any_ff <= (sqf_ff ? 1'b0 : any_ff) | sqp_ff;
      end
   end
   assign stat.any_present = any_ff;

   // sorted best list
   logic [DistW-1:0] bd_ff [0:MaxNeighbours-1];
   logic [PtW-1:0]   bi_ff [0:MaxNeighbours-1];
   logic [CntW-1:0]  cnt_ff;
   logic [SlotW-1:0] pos_ff;
   logic [DistW-1:0] ins_d_ff;
   logic [PtW-1:0]   ins_i_ff;
   logic [SlotW-1:0] lim_m1, pos_m1;
   logic             full;

   assign lim_m1 = SlotW'(limit - CntW'(1));
   assign full   = (cnt_ff == limit);
   assign pos_m1 = pos_ff - SlotW'(1);
   assign stat.ins_take   = !(full && (sum_ff >= bd_ff[lim_m1]));
   assign stat.shift_more = (pos_ff != '0) && (bd_ff[pos_m1] > ins_d_ff);
   assign stat.count      = cnt_ff;
   assign stat.slot_index = bi_ff[cmd.out_slot];

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_list) begin
         cnt_ff <= '0;
      end else if (cmd.ins_check && stat.ins_take) begin
         pos_ff   <= full ? lim_m1 : SlotW'(cnt_ff);
         ins_d_ff <= sum_ff;
         ins_i_ff <= cmd.cand;
         if (!full) begin
            cnt_ff <= cnt_ff + CntW'(1);
         end
      end else if (cmd.shift_step) begin
         if (stat.shift_more) begin
            bd_ff[pos_ff] <= bd_ff[pos_m1];
            bi_ff[pos_ff] <= bi_ff[pos_m1];
            pos_ff        <= pos_m1;
         end else begin
            bd_ff[pos_ff] <= ins_d_ff;
            bi_ff[pos_ff] <= ins_i_ff;
         end
      end
   end
endmodule
`default_nettype wire

FILE: design/knn_control.sv
`timescale 1ns / 1ps
`default_nettype none
module knn_control
   import knn_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic           op,
   input  wire logic [PtW-1:0] point,
   input  wire logic [8:0]     npts,
   input  wire logic [DimW:0]  ndims,
   input  wire knn_stat_type   stat,
   output knn_cmd_type         cmd,
   output logic                busy,
   output logic [PtW-1:0]      target,
   output logic                rsp_valid,
   output logic [PtW-1:0]      rsp_index,
   output logic [SlotW-1:0]    rsp_rank,
   output logic                rsp_none,
   output logic                rsp_last
);
   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_DRAIN, S_INSERT, S_SHIFT, S_EMIT
   } state_type;

   state_type        state_ff;
   logic [PtW-1:0]   tgt_ff;
   logic [8:0]       cand_ff;
   logic [DimW:0]    dim_ff;
   logic [2:0]       drain_ff;
   logic [SlotW-1:0] slot_ff;
   logic             ok_cand;

   assign busy   = (state_ff != S_IDLE);
   assign target = tgt_ff;
   assign ok_cand = (cand_ff[PtW-1:0] != tgt_ff);

   always_comb begin
      cmd = '0;
      cmd.load_wr    = start && !busy && (op == OP_LOAD);
      cmd.clear_list = start && !busy && (op == OP_QUERY);
      cmd.cand       = cand_ff[PtW-1:0];
      cmd.dim        = dim_ff[DimW-1:0];
      cmd.out_slot   = slot_ff;
      if (state_ff == S_READ) begin
         cmd.rd_en     = 1'b1;
         cmd.acc_valid = 1'b1;
         cmd.acc_first = (dim_ff == '0);
      end
      cmd.ins_check  = (state_ff == S_INSERT) && ok_cand && stat.any_present;
      cmd.shift_step = (state_ff == S_SHIFT);
   end

   // read data comes out of the read register; acc_valid is delayed to match
   // by the datapath chain (acc_valid is issued with the read, ahead of the data;
   // drain covers the pipeline)
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start && op == OP_QUERY) begin
                  tgt_ff  <= point;
                  cand_ff <= '0;
                  dim_ff  <= '0;
                  slot_ff <= '0;
                  if ({1'b0, point} < npts && ndims != '0) begin
                     state_ff <= S_READ;
                  end else begin
                     state_ff <= S_EMIT;
                  end
               end
            end
            S_READ: begin
               if (dim_ff + 1'b1 >= ndims || dim_ff == (DimW+1)'(MaxDims-1)) begin
                  dim_ff   <= '0;
                  drain_ff <= '0;
                  state_ff <= S_DRAIN;
               end else begin
                  dim_ff <= dim_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               drain_ff <= drain_ff + 3'd1;
               if (drain_ff == 3'd3) begin
                  state_ff <= S_INSERT;
               end
            end
            S_INSERT: begin
               if (ok_cand && stat.any_present && stat.ins_take) begin
                  state_ff <= S_SHIFT;
               end else if (cand_ff + 9'd1 >= npts) begin
                  state_ff <= S_EMIT;
               end else begin
                  cand_ff  <= cand_ff + 9'd1;
                  state_ff <= S_READ;
               end
            end
            S_SHIFT: begin
               if (!stat.shift_more) begin
                  if (cand_ff + 9'd1 >= npts) begin
                     state_ff <= S_EMIT;
                  end else begin
                     cand_ff  <= cand_ff + 9'd1;
                     state_ff <= S_READ;
                  end
               end
            end
            S_EMIT: begin
               rsp_valid <= 1'b1;
               if (stat.count == '0) begin
                  rsp_index <= '0;
                  rsp_rank  <= '0;
                  rsp_none  <= 1'b1;
                  rsp_last  <= 1'b1;
                  state_ff  <= S_IDLE;
               end else begin
                  rsp_index <= stat.slot_index;
                  rsp_rank  <= slot_ff;
                  rsp_none  <= 1'b0;
                  rsp_last  <= (CntW'(slot_ff) + CntW'(1) == stat.count);
                  slot_ff   <= slot_ff + SlotW'(1);
                  if (CntW'(slot_ff) + CntW'(1) == stat.count) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: design/k_nearest_neighbour_select.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake            Payload
// request   start / busy         req_operation, req_point_index, req_dim_index, req_coord_*
// response  rsp_valid (strobe)   rsp_neighbor_index, rsp_neighbor_rank, rsp_no_neighbor, rsp_last
// csr       csr_valid/csr_ready  csr_index, csr_data
// A query scans each point: a two-port store read per dimension, a pipeline drain, an
// insert check, and for each point that enters the list an insertion shift; then it
// emits one result per cycle. Synchronous reset; the store is not cleared. The
// receiver cannot stall; busy falls in the cycle the last result strobes.
module k_nearest_neighbour_select
   import knn_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_operation,
   input  wire logic [PtW-1:0]       req_point_index,
   input  wire logic [DimW-1:0]      req_dim_index,
   input  wire logic signed [CoordBits-1:0] req_coord_value,
   input  wire logic                 req_coord_missing,
   output logic                      rsp_valid,
   output logic [PtW-1:0]            rsp_neighbor_index,
   output logic [SlotW-1:0]          rsp_neighbor_rank,
   output logic                      rsp_no_neighbor,
   output logic                      rsp_last,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [1:0]           csr_index,
   input  wire logic [15:0]          csr_data
);
   logic [CntW-1:0] ncount_ff, limit;
   logic [8:0]      npts_ff, npts;
   logic [DimW:0]   ndims_ff, ndims;
   knn_cmd_type     cmd;
   knn_stat_type    stat;
   logic [PtW-1:0]  target;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ncount_ff <= CntW'(4);
         npts_ff   <= 9'd256;
         ndims_ff  <= 4'd8;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NEIGHBOR_COUNT: ncount_ff <= csr_data[4:0];
            CSR_POINTS_IN_USE:  npts_ff   <= csr_data[8:0];
            CSR_DIMS_IN_USE:    ndims_ff  <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // clamp to supported ranges
   assign limit = (ncount_ff == '0) ? CntW'(1) :
                  (ncount_ff > CntW'(MaxNeighbours)) ? CntW'(MaxNeighbours) : ncount_ff;
   assign npts  = (npts_ff > 9'(MaxPoints)) ? 9'(MaxPoints) : npts_ff;
   assign ndims = (ndims_ff > 4'(MaxDims)) ? 4'(MaxDims) : ndims_ff;

   knn_control u_ctl (
      .clock, .reset, .start, .op(req_operation), .point(req_point_index),
      .npts, .ndims, .stat, .cmd, .busy, .target,
      .rsp_valid, .rsp_index(rsp_neighbor_index), .rsp_rank(rsp_neighbor_rank),
      .rsp_none(rsp_no_neighbor), .rsp_last
   );

   knn_datapath u_dp (
      .clock, .reset, .cmd, .target,
      .load_dim(req_dim_index), .load_point(req_point_index),
      .load_value(req_coord_value), .load_missing(req_coord_missing),
      .limit, .stat
   );

   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_neighbor |-> rsp_last)
      else $error("no_neighbor result not last");
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("busy after last result");
   // list fill is bounded while a query runs; the limit may change between queries
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      busy |-> stat.count <= limit)
      else $error("list overfilled");
endmodule
`default_nettype wire

FILE: verif/k_nearest_neighbour_select_test.sv
`timescale 1ns / 1ps
module k_nearest_neighbour_select_test;
   import knn_pkg::*;

   localparam int IdleLimit = 60000;
   // points loaded before any query; queries never scan past them
   localparam int FillPoints = 12;

   localparam logic [15:0] PhaseCfg [9][3] = '{
      '{16'd16, 16'd12, 16'd8}, '{16'd1, 16'd10, 16'd3}, '{16'd0, 16'd4, 16'd1},
      '{16'd31, 16'd2, 16'd8}, '{16'd8, 16'd12, 16'd4}, '{16'd5, 16'd0, 16'd8},
      '{16'd3, 16'd11, 16'd0}, '{16'h0fe6, 16'hfe0c, 16'hfff3},
      '{16'd16, 16'd12, 16'd15}};
   localparam int PhaseItems [9] = '{6, 6, 6, 5, 6, 3, 4, 6, 3};

   typedef struct packed {
      logic                 op;
      logic [PtW-1:0]       pt;
      logic [DimW-1:0]      dim;
      logic [CoordBits-1:0] val;
      logic                 miss;
   } knn_req_type;

   typedef struct packed {
      logic [PtW-1:0]   idx;
      logic [SlotW-1:0] rank;
      logic             none;
      logic             last;
   } neighbour_rsp_type;

   logic clock, reset;
   logic start, busy;
   logic req_operation;
   logic [PtW-1:0] req_point_index;
   logic [DimW-1:0] req_dim_index;
   logic signed [CoordBits-1:0] req_coord_value;
   logic req_coord_missing;
   logic rsp_valid;
   logic [PtW-1:0] rsp_neighbor_index;
   logic [SlotW-1:0] rsp_neighbor_rank;
   logic rsp_no_neighbor, rsp_last;
   logic csr_valid, csr_ready;
   logic [1:0] csr_index;
   logic [15:0] csr_data;

   k_nearest_neighbour_select uut (.*);

   // shadow of the store and the registers
   logic signed [CoordBits-1:0] coord_mem [MaxPoints*MaxDims];
   logic miss_mem [MaxPoints*MaxDims];
   logic [4:0] nbr_reg = 5'd4;
   logic [8:0] pts_reg = 9'd256;
   logic [3:0] dims_reg = 4'd8;

   knn_req_type request_queue [$];
   neighbour_rsp_type expected_neighbours [$];
   knn_req_type cur;
   int gap_left;
   int failures = 0;
   int idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // rank candidates against the target, nearest first
   function automatic void predict_query(input logic [PtW-1:0] tgt);
      int limit, npts, ndims, cnt, pos, i, d, k, a, b, diff;
      longint unsigned sum_sq;
      longint unsigned bd [MaxNeighbours];
      int bi [MaxNeighbours];
      bit any;
      limit = (nbr_reg == 0) ? 1 : ((nbr_reg > MaxNeighbours) ? MaxNeighbours : nbr_reg);
      npts = (pts_reg > MaxPoints) ? MaxPoints : pts_reg;
      ndims = (dims_reg > MaxDims) ? MaxDims : dims_reg;
      cnt = 0;
      if (tgt < npts) begin
         for (i = 0; i < npts; i++) begin
            if (i == tgt) continue;
            sum_sq = 0;
            any = 0;
            for (d = 0; d < ndims; d++) begin
               a = tgt * MaxDims + d;
               b = i * MaxDims + d;
               if (!miss_mem[a] && !miss_mem[b]) begin
                  any = 1;
                  diff = int'(coord_mem[a]) - int'(coord_mem[b]);
                  sum_sq += longint'(diff) * longint'(diff);
               end
            end
            if (!any) continue;
            if (cnt == limit && sum_sq >= bd[limit-1]) continue;
            pos = (cnt < limit) ? cnt : limit - 1;
            while (pos > 0 && bd[pos-1] > sum_sq) begin
               bd[pos] = bd[pos-1];
               bi[pos] = bi[pos-1];
               pos--;
            end
            bd[pos] = sum_sq;
            bi[pos] = i;
            if (cnt < limit) cnt++;
         end
      end
      if (cnt == 0) begin
         expected_neighbours.insert(expected_neighbours.size(),
                                    '{idx: '0, rank: '0, none: 1'b1, last: 1'b1});
      end else begin
         for (k = 0; k < cnt; k++)
            expected_neighbours.insert(expected_neighbours.size(),
                                       '{idx: bi[k][PtW-1:0], rank: k[SlotW-1:0],
                                         none: 1'b0, last: (k == cnt - 1)});
      end
   endfunction

   function automatic logic [CoordBits-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2, 3: return 16'($signed($urandom_range(0, 4)) - 2);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic void push_load(input int pt, input int dim,
                                     input logic [CoordBits-1:0] val, input logic miss);
      request_queue.insert(request_queue.size(),
                           '{op: OP_LOAD, pt: pt[PtW-1:0], dim: dim[DimW-1:0],
                             val: val, miss: miss});
   endfunction

   function automatic void push_query(input int pt);
      request_queue.insert(request_queue.size(),
                           '{op: OP_QUERY, pt: pt[PtW-1:0],
                             dim: DimW'($urandom_range(0, 7)),
                             val: 16'($urandom_range(0, 65535)),
                             miss: 1'($urandom_range(0, 1))});
   endfunction

   // request driver
   always @(posedge clock) begin : drive_requests
      logic take, nxt_start, load_next;
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
         req_operation <= 1'b0;
         req_point_index <= '0;
         req_dim_index <= '0;
         req_coord_value <= '0;
         req_coord_missing <= 1'b0;
      end else begin
         take = start && !busy;
         load_next = 1'b0;
         nxt_start = start;
         if (take) begin
            if (cur.op == OP_QUERY) predict_query(cur.pt);
            else begin
               coord_mem[cur.pt * MaxDims + cur.dim] = cur.val;
               miss_mem[cur.pt * MaxDims + cur.dim] = cur.miss;
            end
            nxt_start = 1'b0;
         end
         if (!start || take) begin
            if (gap_left > 0) gap_left <= gap_left - 1;
            else if (request_queue.size() > 0) begin
               load_next = 1'b1;
               gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
            end
         end
         if (load_next) begin
            cur = request_queue.pop_front();
            nxt_start = 1'b1;
            req_operation <= cur.op;
            req_point_index <= cur.pt;
            req_dim_index <= cur.dim;
            req_coord_value <= cur.val;
            req_coord_missing <= cur.miss;
         end
         start <= nxt_start;
      end
   end

   // response checker
   always @(posedge clock) begin : check_responses
      neighbour_rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_neighbours.size() == 0) begin
            $error("unexpected response index %0d", rsp_neighbor_index);
            failures++;
         end else begin
            e = expected_neighbours.pop_front();
            if (rsp_neighbor_index !== e.idx) begin
               $error("neighbor_index expected %0d actual %0d", e.idx, rsp_neighbor_index);
               failures++;
            end
            if (rsp_neighbor_rank !== e.rank) begin
               $error("neighbor_rank expected %0d actual %0d", e.rank, rsp_neighbor_rank);
               failures++;
            end
            if (rsp_no_neighbor !== e.none) begin
               $error("no_neighbor expected %0d actual %0d", e.none, rsp_no_neighbor);
               failures++;
            end
            if (rsp_last !== e.last) begin
               $error("last expected %0d actual %0d", e.last, rsp_last);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= IdleLimit) begin
         $display("Regression FAIL");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // sample at the falling edge so the driver's updates have settled
   task automatic wait_idle();
      while (request_queue.size() != 0 || start || expected_neighbours.size() != 0 || busy)
         @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_NEIGHBOR_COUNT: nbr_reg = data[4:0];
         CSR_POINTS_IN_USE:  pts_reg = data[8:0];
         CSR_DIMS_IN_USE:    dims_reg = data[3:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int p, n, pt, d, npts;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // scan only the points that get loaded
      write_csr(CSR_POINTS_IN_USE, 16'(FillPoints));

      // fill the scanned points; point 5 all missing, points 10 and 11 equal
      for (pt = 0; pt < FillPoints; pt++)
         for (d = 0; d < MaxDims; d++) begin
            if (pt == 5) push_load(pt, d, 16'h1234, 1'b1);
            else if (pt == 10 || pt == 11) push_load(pt, d, 16'(16'h0100 * d), 1'b0);
            else push_load(pt, d, rand_coord(), ($urandom_range(0, 3) == 0));
         end
      push_load(0, 0, 16'h8000, 1'b0);
      push_load(1, 0, 16'h7fff, 1'b0);
      push_query(0);
      push_query(5);
      push_query(10);
      push_query(255);
      wait_idle();

      // target outside the scanned points, then a target inside them
      write_csr(CSR_POINTS_IN_USE, 16'd8);
      push_query(200);
      push_query(7);
      wait_idle();

      for (p = 0; p < 9; p++) begin
         write_csr(CSR_NEIGHBOR_COUNT, PhaseCfg[p][0]);
         write_csr(CSR_POINTS_IN_USE, PhaseCfg[p][1]);
         write_csr(CSR_DIMS_IN_USE, PhaseCfg[p][2]);
         npts = (pts_reg > MaxPoints) ? MaxPoints : pts_reg;
         for (n = 0; n < PhaseItems[p]; n++) begin
            if ($urandom_range(0, 9) < 3)
               push_load($urandom_range(0, FillPoints - 1), $urandom_range(0, 7),
                         rand_coord(), ($urandom_range(0, 3) == 0));
            else if (npts == 0 || $urandom_range(0, 7) == 0)
               push_query($urandom_range(0, 255));
            else
               push_query($urandom_range(0, npts - 1));
         end
         wait_idle();
      end

      repeat (50) @(posedge clock);
      if (failures == 0 && expected_neighbours.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule

FILE: k_nearest_neighbour_select.f
design/knn_pkg.sv
design/knn_datapath.sv
design/knn_control.sv
design/k_nearest_neighbour_select.sv
verif/k_nearest_neighbour_select_test.sv
